/* design/base26_string_to_integer_core_defines.svh */
// assertion macros for the base-26 string converter
`ifndef BASE26_STRING_TO_INTEGER_CORE_DEFINES_SVH
`define BASE26_STRING_TO_INTEGER_CORE_DEFINES_SVH

`ifndef SYNTH

// checked only out of reset
`define B26_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define B26_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define B26_ASSERT_RUN(label, prop, msg)
`define B26_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* design/b26s2i_pkg.sv */
package b26s2i_pkg;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_SEEK   = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] CFG_MAX_DIGITS    = 2'd0;
    localparam logic [1:0] CFG_SIGNED_MODE   = 2'd1;
    localparam logic [1:0] CFG_OVERFLOW_MASK = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [4:0]  max_digits;
        logic        signed_mode;
        logic [63:0] overflow_mask;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic        upper_case;
        logic [63:0] accumulator;
        logic [63:0] place_weight;
        logic [4:0]  digit_count;
        logic [1:0]  error_code;
        logic        negate_flag;
    } conv_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        max_digits:    5'd7,
        signed_mode:   1'b1,
        overflow_mask: 64'hFFFF_FFFF_8000_0000
    };

    localparam conv_state_t STATE_RESET = '{
        phase:        PH_SKIP,
        upper_case:   1'b0,
        accumulator:  64'd0,
        place_weight: 64'd1,
        digit_count:  5'd0,
        error_code:   STATUS_OK,
        negate_flag:  1'b0
    };

    function automatic logic is_white(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

/* design/b26s2i_step.sv */
module b26s2i_step (
    input  b26s2i_pkg::conv_state_t state_cur,
    input  b26s2i_pkg::cfg_t        cfg,
    input  logic [7:0]              character,
    input  logic                    final_req,
    output b26s2i_pkg::conv_state_t state_next,
    output b26s2i_pkg::result_t     result
);
    import b26s2i_pkg::*;

    logic        is_ws;
    logic        is_up;
    logic        use_upper;
    logic        take;
    logic        saturated;
    logic        beyond;
    logic        check_here;
    logic [7:0]  base;
    logic [7:0]  top;
    logic [7:0]  offs;
    logic [4:0]  digit;
    logic [4:0]  cnt_n;
    logic [63:0] adder;
    logic [63:0] sum;
    logic [63:0] w26;
    logic [63:0] neg_acc;
    logic        m1;
    logic        m2;
    logic        mr;
    logic        ovf;
    conv_state_t st;

    always_comb begin
        is_ws     = is_white(character);
        is_up     = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_Z);
        use_upper = (state_cur.phase == PH_SKIP) ? is_up : state_cur.upper_case;
        base      = use_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        top       = use_upper ? CHAR_UPPER_Z : CHAR_LOWER_Z;
        offs      = character - base;
        digit     = offs[4:0];

        saturated  = (state_cur.digit_count == COUNT_MAX);
        cnt_n      = saturated ? COUNT_MAX : state_cur.digit_count + 5'd1;
        beyond     = saturated || (cnt_n > cfg.max_digits);
        check_here = !saturated && (cnt_n == cfg.max_digits);

        adder = 64'(digit) * state_cur.place_weight;
        sum   = state_cur.accumulator + adder;
        // weight times 26 as shifts: 16 + 8 + 2
        w26   = (state_cur.place_weight << 4) + (state_cur.place_weight << 3)
              + (state_cur.place_weight << 1);

        m1  = |(state_cur.accumulator & cfg.overflow_mask);
        m2  = |(adder & cfg.overflow_mask);
        mr  = |(sum & cfg.overflow_mask);
        ovf = cfg.signed_mode ? (m1 || m2 || mr) : ((m1 && m2) || ((m1 || m2) && !mr));

        neg_acc = 64'd0 - state_cur.accumulator;

        take = ((state_cur.phase == PH_SKIP) && !is_ws) || (state_cur.phase == PH_DIGITS);
        st   = state_cur;

        case (state_cur.phase)
            PH_SKIP: begin
                if (!is_ws) begin
                    st.upper_case = is_up;
                end
            end
            PH_SEEK: begin
                if (!is_ws) begin
                    if (character == CHAR_MINUS) begin
                        st.negate_flag = 1'b1;
                    end
                    st.phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (take) begin
            st.phase = PH_DIGITS;
            if ((character == CHAR_PLUS) || (character == CHAR_MINUS)) begin
                if (character == CHAR_MINUS) begin
                    st.negate_flag = 1'b1;
                end
                st.phase = PH_DONE;
            end else if (is_ws) begin
                st.phase = PH_SEEK;
            end else if ((character < base) || (character > top)) begin
                st.error_code = STATUS_INVALID;
                st.phase      = PH_DONE;
            end else begin
                st.digit_count = cnt_n;
                if (beyond && (digit != 5'd0)) begin
                    st.error_code = STATUS_OVERFLOW;
                    st.phase      = PH_DONE;
                end else if (check_here && ovf) begin
                    st.accumulator = sum;
                    st.error_code  = STATUS_OVERFLOW;
                    st.phase       = PH_DONE;
                end else begin
                    st.accumulator  = sum;
                    st.place_weight = w26;
                end
            end
        end

        // a minus never adds a digit, so the old accumulator is the one to negate
        if (st.phase == PH_SKIP) begin
            result.value  = 64'd0;
            result.status = STATUS_INVALID;
        end else if (st.error_code != STATUS_OK) begin
            result.value  = 64'd0;
            result.status = st.error_code;
        end else begin
            result.value  = st.negate_flag ? neg_acc : st.accumulator;
            result.status = STATUS_OK;
        end

        state_next = final_req ? STATE_RESET : st;
    end

endmodule

/* design/base26_string_to_integer_core.sv */
// base-26 alphabetic string to integer converter
// input channel: s_valid/s_ready carry one string byte per transaction, last
// character first; s_final_req marks the string's first character and closes it.
// result channel: m_valid/m_ready carry m_value (64-bit two's complement, 0 on
// error) and m_status (ok, invalid, overflow), one transaction per string.
// configuration: cfg_wr_en writes cfg_data to register cfg_index at once
// (0 max_digits, 1 signed_mode, 2 overflow_mask); write only while idle.
// throughput: one byte per cycle unless a final byte waits on a held result,
// set by the combinational multiply-add of the digit into the accumulator
// between the input and result registers. a byte waits in the input register
// and is folded into the state when it advances; a final byte's result is
// loaded into the result register at that same edge, which raises m_valid.
// stall: while a result waits for m_ready, non-final bytes keep flowing; a final
// byte waits in the input register and s_ready drops until the result is taken.
// reset (aresetn low, synchronous): both channels empty, conversion state
// cleared, registers back to max_digits 7, signed rule, mask 0xFFFFFFFF80000000.
`include "base26_string_to_integer_core_defines.svh"

module base26_string_to_integer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_final_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic [1:0]  m_status,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import b26s2i_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  char_reg;
    logic        final_reg;
    logic        in_take;
    logic        advance;

    conv_state_t state_reg;
    conv_state_t state_next;
    conv_state_t step_state;
    result_t     step_result;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    logic        m_valid_reg;
    logic        m_valid_next;
    result_t     result_reg;

    b26s2i_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .character (char_reg),
        .final_req (final_reg),
        .state_next(step_state),
        .result    (step_result)
    );

    // a final byte moves on only when the result register is free or draining
    always_comb begin
        advance       = in_valid_reg && (!final_reg || !m_valid_reg || m_ready);
        s_ready       = !in_valid_reg || advance;
        in_take       = s_valid && s_ready;
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        state_next    = advance ? step_state : state_reg;
        m_valid_next  = (advance && final_reg) ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_DIGITS:    cfg_next.max_digits    = cfg_data[4:0];
                CFG_SIGNED_MODE:   cfg_next.signed_mode   = cfg_data[0];
                CFG_OVERFLOW_MASK: cfg_next.overflow_mask = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
            cfg_reg      <= CFG_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            char_reg  <= s_character;
            final_reg <= s_final_req;
        end
        if (advance && final_reg) begin
            result_reg <= step_result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = result_reg.value;
    assign m_status = result_reg.status;

    `B26_ASSERT_RUN(a_err_value_zero,
        (m_valid && (m_status != STATUS_OK)) |-> (m_value == 64'd0),
        "error result with nonzero value")
    `B26_ASSERT_RUN(a_clear_after_final,
        (advance && final_reg) |=> ((state_reg.phase == PH_SKIP)
            && (state_reg.digit_count == 5'd0) && (state_reg.place_weight == 64'd1)),
        "state not cleared after final byte")
    `B26_ASSERT_RUN(a_final_waits,
        (in_valid_reg && final_reg && m_valid_reg && !m_ready) |=> (in_valid_reg && final_reg),
        "final byte left while result stalled")
    `B26_ASSERT_ALWAYS(a_reset_empty,
        !aresetn |=> (!m_valid_reg && !in_valid_reg),
        "channels not empty after reset")

endmodule

/* dv/b26s2i_conversion_checker.sv */
`timescale 1ns / 1ps

module b26s2i_conversion_checker
    import b26s2i_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_final_req,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_value,
    input  logic [1:0]  m_status,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatch_count,
    output int          outstanding
);

    cfg_t        cfg;
    conv_state_t conv;
    result_t     expected_conversions[$];
    int          mismatches = 0;

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // one byte while collecting letters
    function automatic void take_letter(input logic [7:0] c);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [4:0]  digit;
        logic [4:0]  prev_count;
        logic [4:0]  new_count;
        logic [63:0] addend;
        logic        acc_hit;
        logic        add_hit;
        logic        sum_hit;
        logic        ovf;
        if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
            if (c == CHAR_MINUS)
                conv.negate_flag = 1'b1;
            conv.phase = PH_DONE;
            return;
        end
        if (blank_char(c)) begin
            conv.phase = PH_SEEK;
            return;
        end
        lo = conv.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A;
        hi = conv.upper_case ? CHAR_UPPER_Z : CHAR_LOWER_Z;
        if ((c < lo) || (c > hi)) begin
            conv.error_code = STATUS_INVALID;
            conv.phase = PH_DONE;
            return;
        end
        digit = 5'(c - lo);
        prev_count = conv.digit_count;
        new_count = (prev_count < COUNT_MAX) ? prev_count + 5'd1 : COUNT_MAX;
        conv.digit_count = new_count;
        if (((prev_count == COUNT_MAX) || (new_count > cfg.max_digits)) && (digit != 5'd0)) begin
            conv.error_code = STATUS_OVERFLOW;
            conv.phase = PH_DONE;
            return;
        end
        addend = conv.place_weight * {59'd0, digit};
        if ((prev_count != COUNT_MAX) && (new_count == cfg.max_digits)) begin
            acc_hit = (conv.accumulator & cfg.overflow_mask) != 64'd0;
            add_hit = (addend & cfg.overflow_mask) != 64'd0;
            conv.accumulator = conv.accumulator + addend;
            sum_hit = (conv.accumulator & cfg.overflow_mask) != 64'd0;
            if (cfg.signed_mode)
                ovf = acc_hit || add_hit || sum_hit;
            else
                ovf = (acc_hit && add_hit) || ((acc_hit || add_hit) && !sum_hit);
            if (ovf) begin
                conv.error_code = STATUS_OVERFLOW;
                conv.phase = PH_DONE;
                return;
            end
        end else begin
            conv.accumulator = conv.accumulator + addend;
        end
        conv.place_weight = conv.place_weight * 64'd26;
    endfunction

    // returns 1 when the byte closes a string, with its conversion in res
    function automatic bit scan_byte(input logic [7:0] c, input logic fin,
                                     output result_t res);
        res = '0;
        case (conv.phase)
            PH_SKIP: if (!blank_char(c)) begin
                conv.upper_case = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
                conv.phase = PH_DIGITS;
                take_letter(c);
            end
            PH_DIGITS: take_letter(c);
            PH_SEEK: if (!blank_char(c)) begin
                if (c == CHAR_MINUS)
                    conv.negate_flag = 1'b1;
                conv.phase = PH_DONE;
            end
            default: ;
        endcase
        if (!fin)
            return 1'b0;
        if (conv.phase == PH_SKIP)
            res.status = STATUS_INVALID;
        else if (conv.error_code != STATUS_OK)
            res.status = conv.error_code;
        else
            res.value = conv.negate_flag ? 64'd0 - conv.accumulator : conv.accumulator;
        conv = STATE_RESET;
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what, input result_t want,
                                         input result_t got);
        if (mismatches < 10)
            $display("%0t: %s: expected value %h status %0d, got value %h status %0d",
                     $time, what, want.value, want.status, got.value, got.status);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            cfg = CFG_RESET;
            conv = STATE_RESET;
            expected_conversions.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_DIGITS:    cfg.max_digits = cfg_data[4:0];
                    CFG_SIGNED_MODE:   cfg.signed_mode = cfg_data[0];
                    CFG_OVERFLOW_MASK: cfg.overflow_mask = cfg_data;
                    default: ;
                endcase
            end
            // result transaction first: it always belongs to an earlier string
            if (m_valid && m_ready) begin
                got.value = m_value;
                got.status = m_status;
                if (expected_conversions.size() == 0) begin
                    note_failure("result with nothing pending", '0, got);
                end else begin
                    want = expected_conversions.pop_front();
                    if ((got.value !== want.value) || (got.status !== want.status))
                        note_failure("result mismatch", want, got);
                end
            end
            if (s_valid && s_ready) begin
                if (scan_byte(s_character, s_final_req, fresh))
                    expected_conversions.push_back(fresh);
            end
        end
        mismatch_count <= mismatches;
        outstanding <= expected_conversions.size();
    end

endmodule

/* dv/tb_base26_string_to_integer_core.sv */
`timescale 1ns / 1ps

module tb_base26_string_to_integer_core;
    import b26s2i_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTINGS_COUNT = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_character;
    logic        s_final_req;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value;
    logic [1:0]  m_status;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int          mismatch_count;
    int          outstanding;
    int          quiet_cycles = 0;
    int          sent_items = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          hold_req = 1'b0;
    logic [7:0]  text_q[$];

    base26_string_to_integer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_final_req (s_final_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    b26s2i_conversion_checker u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_character    (s_character),
        .s_final_req    (s_final_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_status       (m_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // counts cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
            $display("** base26_string_to_integer_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side, with one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_character <= c;
        s_final_req <= fin;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // bytes go out last character first, the first one flagged as final
    task automatic send_text();
        for (int i = text_q.size() - 1; i >= 0; i--)
            send_byte(text_q[i], i == 0);
        text_q.delete();
    endtask

    task automatic add_byte(input logic [7:0] c);
        text_q.push_back(c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] random_blank();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CHAR_SPACE : 8'(CHAR_TAB + k);
    endfunction

    function automatic logic [4:0] random_digit();
        int k;
        k = $urandom_range(5);
        if (k < 2)
            return 5'd25;
        else if (k == 2)
            return 5'd0;
        return 5'($urandom_range(25));
    endfunction

    task automatic build_random_text(input int md);
        int         kind;
        int         sign;
        int         pad;
        int         sig;
        logic [7:0] base;
        kind = $urandom_range(99);
        if (kind < 15) begin
            // raw noise, sometimes nothing but whitespace
            repeat ($urandom_range(1, 6))
                add_byte(($urandom_range(3) == 0) ? random_blank() : 8'($urandom_range(255)));
        end else begin
            base = $urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A;
            repeat ($urandom_range(2))
                add_byte(random_blank());
            sign = $urandom_range(2);
            if (sign == 1)
                add_byte(CHAR_PLUS);
            else if (sign == 2)
                add_byte(CHAR_MINUS);
            if (sign != 0)
                repeat ($urandom_range(1))
                    add_byte(random_blank());
            // leading zero letters, now and then enough to saturate the count
            pad = ($urandom_range(9) == 0) ? $urandom_range(3, 34) : $urandom_range(2);
            sig = $urandom_range(0, (md > 28) ? 29 : md + 1);
            repeat (pad)
                add_byte(base);
            repeat (sig)
                add_byte(base + random_digit());
            repeat ($urandom_range(2))
                add_byte(random_blank());
            if ((kind < 30) && (text_q.size() > 0))
                text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
        end
        if (text_q.size() == 0)
            add_byte(CHAR_SPACE);
    endtask

    task automatic write_setting(input logic [4:0] md, input logic sm, input logic [63:0] mask);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_DIGITS;
        cfg_data <= {59'd0, md};
        @(negedge aclk);
        cfg_index <= CFG_SIGNED_MODE;
        cfg_data <= {63'd0, sm};
        @(negedge aclk);
        cfg_index <= CFG_OVERFLOW_MASK;
        cfg_data <= mask;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [4:0]  md;
        logic        sm;
        logic [63:0] mask;
        int          phase_start;
        bit          hold_done;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_character = 8'd0;
        s_final_req = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MAX_DIGITS;
        cfg_data = 64'd0;
        md = 5'd7;
        hold_done = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed strings at the reset settings
        add_text(" ");
        send_text();
        add_byte(CHAR_TAB);
        add_byte(CHAR_CR);
        send_text();
        add_text("z");
        send_text();
        add_text("BZ");
        send_text();
        add_text("-b");
        send_text();
        add_text("+");
        send_text();
        add_text("-");
        add_byte(CHAR_TAB);
        add_text("b ");
        send_text();
        add_text("q-b");
        send_text();
        add_text("aB");
        send_text();
        add_byte(8'hFF);
        send_text();
        add_byte(8'h00);
        send_text();
        // just past the signed 32-bit limit at the seventh letter
        add_text("gzzzzzz");
        send_text();

        for (int p = 0; p < SETTINGS_COUNT; p++) begin
            if (p != 0) begin
                case (p)
                    1: begin md = 5'd1;  sm = 1'b0; mask = 64'hFFFF_FFFF_0000_0000; end
                    2: begin md = 5'd28; sm = 1'b1; mask = 64'h8000_0000_0000_0000; end
                    3: begin md = 5'd13; sm = 1'b0; mask = 64'h8000_0000_0000_0000; end
                    4: begin md = 5'd0;  sm = 1'b1; mask = 64'hFFFF_FFFF_FFFF_FFFF; end
                    5: begin md = 5'd31; sm = 1'b0; mask = 64'd0; end
                    6: begin
                        md = 5'($urandom_range(1, 28));
                        sm = 1'($urandom_range(1));
                        mask = 64'hFFFF_FFFF_FFFF_FFFF << $urandom_range(63);
                    end
                    default: begin md = 5'd4; sm = 1'b1; mask = 64'hFFFF_FFFF_FFFF_8000; end
                endcase
                write_setting(md, sm, mask);
            end
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            phase_start = sent_items;
            while (sent_items < phase_start + ITEMS_PER_PHASE) begin
                build_random_text(md);
                send_text();
                // starve the result side once so the input backs up
                if (!hold_done && (sent_items >= phase_start + 60)) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
            end
            wait_idle();
        end

        if ((mismatch_count == 0) && (outstanding == 0))
            $display("** base26_string_to_integer_core: PASSED **");
        else
            $display("** base26_string_to_integer_core: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/b26s2i_pkg.sv
design/b26s2i_step.sv
design/base26_string_to_integer_core.sv
dv/b26s2i_conversion_checker.sv
dv/tb_base26_string_to_integer_core.sv
